FILE: design/ftx_pkg.sv
// Shared constants and item types for the Ethernet/IPv4 five-tuple extractor.
package ftx_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 16;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    localparam int OFF_ETYPE_HI  = 12;
    localparam int OFF_ETYPE_LO  = 13;
    localparam int OFF_IP_START  = 14;
    localparam int OFF_PROTO     = 23;
    localparam int OFF_SRC_FIRST = 26;
    localparam int OFF_SRC_LAST  = 29;
    localparam int OFF_DST_FIRST = 30;
    localparam int OFF_DST_LAST  = 33;
    localparam int PORT_LAST_REL = 3;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] wire_length;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic        truncated;
        logic [15:0] frame_length;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [4:0]  protocol_number;
    } t_out_item;

endpackage

FILE: design/ftx_if.sv
// Valid/ready channel interfaces for frame bytes and five-tuple records.
interface ftx_in_if;
    logic             valid;
    logic             ready;
    ftx_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface ftx_out_if;
    logic               valid;
    logic               ready;
    ftx_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: design/ftx_parser.sv
// Per-frame capture state and record decision for one frame byte.
module ftx_parser #(
    parameter int LENGTH_WIDTH = ftx_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  ftx_pkg::t_in_item  i_item,
    output logic               o_emit,
    output ftx_pkg::t_out_item o_result
);

    typedef logic [LENGTH_WIDTH-1:0] t_off;

    t_off        r_byte_offset, n_byte_offset;
    logic [15:0] r_ether_type, n_ether_type;
    logic [3:0]  r_header_words, n_header_words;
    logic [7:0]  r_protocol, n_protocol;
    logic [31:0] r_src_addr, n_src_addr;
    logic [31:0] r_dst_addr, n_dst_addr;
    logic [31:0] r_ports, n_ports;

    t_off       off;
    logic [7:0] b;
    logic [6:0] port_base;
    logic [6:0] port_last;
    logic       short_eth;
    logic       short_ip;
    logic       short_tuple;
    logic       is_ipv4;
    logic       is_tcp_udp;

    assign off = r_byte_offset;
    assign b   = i_item.data_byte;

    always_comb begin
        n_ether_type = r_ether_type;
        if (off == t_off'(ftx_pkg::OFF_ETYPE_HI) || off == t_off'(ftx_pkg::OFF_ETYPE_LO)) begin
            n_ether_type = {r_ether_type[7:0], b};
        end
        n_header_words = (off == t_off'(ftx_pkg::OFF_IP_START)) ? b[3:0] : r_header_words;
        n_protocol     = (off == t_off'(ftx_pkg::OFF_PROTO)) ? b : r_protocol;
        n_src_addr = r_src_addr;
        if (off >= t_off'(ftx_pkg::OFF_SRC_FIRST) && off <= t_off'(ftx_pkg::OFF_SRC_LAST)) begin
            n_src_addr = {r_src_addr[23:0], b};
        end
        n_dst_addr = r_dst_addr;
        if (off >= t_off'(ftx_pkg::OFF_DST_FIRST) && off <= t_off'(ftx_pkg::OFF_DST_LAST)) begin
            n_dst_addr = {r_dst_addr[23:0], b};
        end
        port_base = 7'(ftx_pkg::OFF_IP_START) + {1'b0, n_header_words, 2'b00};
        port_last = port_base + 7'(ftx_pkg::PORT_LAST_REL);
        n_ports = r_ports;
        if (off >= t_off'(port_base) && off <= t_off'(port_last)) begin
            n_ports = {r_ports[23:0], b};
        end
        n_byte_offset = (off == '1) ? off : off + t_off'(1);
    end

    // Offset compares stand in for "byte count below n" (count = offset + 1).
    always_comb begin
        short_eth   = off < t_off'(ftx_pkg::OFF_ETYPE_LO);
        short_ip    = off < t_off'(ftx_pkg::OFF_PROTO);
        short_tuple = (off < t_off'(ftx_pkg::OFF_DST_LAST)) || (off < t_off'(port_last));
        is_ipv4     = n_ether_type == ftx_pkg::ETHERTYPE_IPV4;
        is_tcp_udp  = (n_protocol == ftx_pkg::PROTO_TCP) || (n_protocol == ftx_pkg::PROTO_UDP);

        o_result              = '0;
        o_result.frame_length = i_item.wire_length;
        o_emit                = i_item.last_byte;
        if (short_eth) begin
            o_result.truncated = 1'b1;
        end else if (is_ipv4) begin
            o_result.kind = 1'b1;
            if (short_ip) begin
                o_result.truncated = 1'b1;
            end else if (!is_tcp_udp) begin
                o_emit = 1'b0;
            end else begin
                o_result.protocol_number = n_protocol[4:0];
                if (short_tuple) begin
                    o_result.truncated = 1'b1;
                end else begin
                    o_result.source_address      = n_src_addr;
                    o_result.destination_address = n_dst_addr;
                    o_result.source_port         = n_ports[31:16];
                    o_result.destination_port    = n_ports[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last_byte)) begin
            r_byte_offset  <= '0;
            r_ether_type   <= '0;
            r_header_words <= '0;
            r_protocol     <= '0;
            r_src_addr     <= '0;
            r_dst_addr     <= '0;
            r_ports        <= '0;
        end else if (i_step) begin
            r_byte_offset  <= n_byte_offset;
            r_ether_type   <= n_ether_type;
            r_header_words <= n_header_words;
            r_protocol     <= n_protocol;
            r_src_addr     <= n_src_addr;
            r_dst_addr     <= n_dst_addr;
            r_ports        <= n_ports;
        end
    end

endmodule

FILE: design/eth_ipv4_five_tuple_extractor.sv
// Top level of the Ethernet/IPv4 five-tuple extractor.
// Takes one frame byte per item and accepts a new item every clock cycle; a byte
// is held in an input register, passes the capture logic and the record, if any,
// lands in the output register, so a record reaches the output only after its
// last byte has passed the input register. Throughput drops only while the
// output register holds a record that the sink does not take. The byte offset
// counter is LENGTH_WIDTH bits wide and sticks at its maximum on very long frames.
module eth_ipv4_five_tuple_extractor #(
    parameter int LENGTH_WIDTH = ftx_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ftx_in_if.sink    i_in,
    ftx_out_if.source o_out
);

    logic               r_s1_valid;
    ftx_pkg::t_in_item  r_s1_item;
    logic               r_out_valid;
    ftx_pkg::t_out_item r_out_item;

    logic               s1_fire;
    logic               emit;
    ftx_pkg::t_out_item result;

    assign s1_fire     = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_fire;
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    ftx_parser #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_fire),
        .i_item  (r_s1_item),
        .o_emit  (emit),
        .o_result(result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_item <= i_in.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && emit) begin
            r_out_item <= result;
        end
    end

endmodule

FILE: design/ftx_checker.sv
// Port-level checks on the five-tuple extractor's record channel.
module ftx_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ftx_pkg::t_out_item i_out_item
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("record dropped while stalled");

    a_item_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_item))
        else $error("record changed while stalled");

    a_non_ip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_item.kind |->
            i_out_item.source_address == '0 && i_out_item.destination_address == '0 &&
            i_out_item.source_port == '0 && i_out_item.destination_port == '0 &&
            i_out_item.protocol_number == '0)
        else $error("non-IPv4 record carries tuple fields");

    a_full_proto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.kind && !i_out_item.truncated |->
            i_out_item.protocol_number == ftx_pkg::PROTO_TCP[4:0] ||
            i_out_item.protocol_number == ftx_pkg::PROTO_UDP[4:0])
        else $error("complete five-tuple without TCP or UDP protocol");

    a_trunc_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.truncated |->
            i_out_item.source_address == '0 && i_out_item.destination_port == '0)
        else $error("truncated record carries captured fields");

endmodule

bind eth_ipv4_five_tuple_extractor ftx_checker u_ftx_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_item (o_out.item)
);

FILE: dv/ftx_record_checker.sv
// Checker for the five-tuple extractor: predicts the records and compares them.
module ftx_record_checker #(
    parameter int LENGTH_WIDTH = ftx_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ftx_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ftx_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_records_pending
);

    logic [LENGTH_WIDTH-1:0] offset_count;
    logic [15:0]             etype_acc;
    logic [3:0]              ihl_words;
    logic [7:0]              proto_byte;
    logic [31:0]             src_acc;
    logic [31:0]             dst_acc;
    logic [31:0]             ports_acc;

    ftx_pkg::t_out_item record_q[$];
    ftx_pkg::t_out_item want_rec;
    ftx_pkg::t_out_item new_rec;
    logic               new_emit;
    int                 fail_total = 0;

    assign o_fail_count = fail_total;

    task automatic clear_frame();
        offset_count = '0;
        etype_acc    = '0;
        ihl_words    = '0;
        proto_byte   = '0;
        src_acc      = '0;
        dst_acc      = '0;
        ports_acc    = '0;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got %h, want %h", field, got, want);
        fail_total++;
    endtask

    // One frame byte through header capture; last byte may give a record.
    task automatic parse_byte(input ftx_pkg::t_in_item it, output logic emit,
                              output ftx_pkg::t_out_item rec);
        logic [LENGTH_WIDTH-1:0] off;
        logic [7:0]              b;
        longint                  count;
        longint                  port_base;
        off  = offset_count;
        b    = it.data_byte;
        emit = 1'b0;
        rec  = '0;
        if (off == ftx_pkg::OFF_ETYPE_HI || off == ftx_pkg::OFF_ETYPE_LO)
            etype_acc = {etype_acc[7:0], b};
        if (off == ftx_pkg::OFF_IP_START) ihl_words = b[3:0];
        if (off == ftx_pkg::OFF_PROTO) proto_byte = b;
        if (off >= ftx_pkg::OFF_SRC_FIRST && off <= ftx_pkg::OFF_SRC_LAST)
            src_acc = {src_acc[23:0], b};
        if (off >= ftx_pkg::OFF_DST_FIRST && off <= ftx_pkg::OFF_DST_LAST)
            dst_acc = {dst_acc[23:0], b};
        port_base = ftx_pkg::OFF_IP_START + 4 * longint'(ihl_words);
        if (off >= port_base && off <= port_base + ftx_pkg::PORT_LAST_REL)
            ports_acc = {ports_acc[23:0], b};
        if (off != '1) offset_count = off + 1'b1;
        if (it.last_byte) begin
            count = longint'(off) + 1;
            emit = 1'b1;
            rec.frame_length = it.wire_length;
            if (count < ftx_pkg::OFF_IP_START) begin
                rec.truncated = 1'b1;
            end else if (etype_acc == ftx_pkg::ETHERTYPE_IPV4) begin
                rec.kind = 1'b1;
                if (count < ftx_pkg::OFF_PROTO + 1) begin
                    rec.truncated = 1'b1;
                end else if (proto_byte != ftx_pkg::PROTO_TCP &&
                             proto_byte != ftx_pkg::PROTO_UDP) begin
                    emit = 1'b0;
                    rec  = '0;
                end else begin
                    rec.protocol_number = proto_byte[4:0];
                    if (count < ftx_pkg::OFF_DST_LAST + 1 ||
                        count < port_base + ftx_pkg::PORT_LAST_REL + 1) begin
                        rec.truncated = 1'b1;
                    end else begin
                        rec.source_address      = src_acc;
                        rec.destination_address = dst_acc;
                        rec.source_port         = ports_acc[31:16];
                        rec.destination_port    = ports_acc[15:0];
                    end
                end
            end
            clear_frame();
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            record_q.delete();
            o_records_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (record_q.size() == 0) begin
                    report_mismatch("unexpected record length",
                                    32'(i_out_item.frame_length), 32'd0);
                end else begin
                    want_rec = record_q.pop_front();
                    if (i_out_item.kind !== want_rec.kind)
                        report_mismatch("kind", 32'(i_out_item.kind), 32'(want_rec.kind));
                    if (i_out_item.truncated !== want_rec.truncated)
                        report_mismatch("truncated", 32'(i_out_item.truncated),
                                        32'(want_rec.truncated));
                    if (i_out_item.frame_length !== want_rec.frame_length)
                        report_mismatch("frame_length", 32'(i_out_item.frame_length),
                                        32'(want_rec.frame_length));
                    if (i_out_item.source_address !== want_rec.source_address)
                        report_mismatch("source_address", i_out_item.source_address,
                                        want_rec.source_address);
                    if (i_out_item.destination_address !== want_rec.destination_address)
                        report_mismatch("destination_address", i_out_item.destination_address,
                                        want_rec.destination_address);
                    if (i_out_item.source_port !== want_rec.source_port)
                        report_mismatch("source_port", 32'(i_out_item.source_port),
                                        32'(want_rec.source_port));
                    if (i_out_item.destination_port !== want_rec.destination_port)
                        report_mismatch("destination_port", 32'(i_out_item.destination_port),
                                        32'(want_rec.destination_port));
                    if (i_out_item.protocol_number !== want_rec.protocol_number)
                        report_mismatch("protocol_number", 32'(i_out_item.protocol_number),
                                        32'(want_rec.protocol_number));
                end
            end
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_in_item, new_emit, new_rec);
                if (new_emit) record_q = {record_q, new_rec};
            end
            o_records_pending <= record_q.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// Top of the five-tuple extractor testbench: clock, reset, frame stimulus and verdict.
module testbench;

    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONE} t_fill;
    typedef enum int {SINK_ALWAYS, SINK_MOSTLY, SINK_RARELY, SINK_TOGGLE} t_sink_mode;

    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [15:0] ETYPE_NEAR = 16'h0801;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   records_pending;
    int   burst_left = 0;
    int   bytes_sent = 0;

    ftx_in_if  u_in ();
    ftx_out_if u_out ();

    eth_ipv4_five_tuple_extractor u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    ftx_record_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (u_in.valid),
        .i_in_ready        (u_in.ready),
        .i_in_item         (u_in.item),
        .i_out_valid       (u_out.valid),
        .i_out_ready       (u_out.ready),
        .i_out_item        (u_out.item),
        .o_fail_count      (fail_count),
        .o_records_pending (records_pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #20000000;
        $display("FAIL");
        $finish;
    end

    // Sink side: ready follows a mode chosen at random: always, mostly, rarely or toggling.
    initial begin
        t_sink_mode mode;
        int         mode_left;
        mode      = SINK_ALWAYS;
        mode_left = 0;
        u_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
                SINK_ALWAYS: begin
                    u_out.ready <= 1'b1;
                end
                SINK_MOSTLY: begin
                    u_out.ready <= ($urandom_range(0, 3) != 0);
                end
                SINK_RARELY: begin
                    u_out.ready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    u_out.ready <= !u_out.ready;
                end
            endcase
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input logic [15:0] wlen);
        ftx_pkg::t_in_item it;
        int                gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                u_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 32);
        end
        burst_left--;
        it.data_byte   = b;
        it.last_byte   = last;
        it.wire_length = wlen;
        u_in.valid <= 1'b1;
        u_in.item  <= it;
        @(posedge i_clk);
        while (!u_in.ready) @(posedge i_clk);
    endtask

    task automatic send_frame(input int len, input bit shaped, input logic [15:0] etype,
                              input logic [3:0] ihl, input logic [7:0] proto,
                              input logic [15:0] wlen, input t_fill fill);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZERO: b = 8'h00;
                FILL_ONE:  b = 8'hFF;
                default:   b = 8'($urandom);
            endcase
            if (shaped) begin
                if (i == ftx_pkg::OFF_ETYPE_HI) b = etype[15:8];
                if (i == ftx_pkg::OFF_ETYPE_LO) b = etype[7:0];
                if (i == ftx_pkg::OFF_IP_START) b = {b[7:4], ihl};
                if (i == ftx_pkg::OFF_PROTO) b = proto;
            end
            send_byte(b, i == len - 1, (i == len - 1) ? wlen : 16'($urandom));
        end
        bytes_sent += len;
    endtask

    initial begin
        int         r;
        int         ihl;
        int         need;
        int         len;
        logic [7:0] proto;
        i_rst_n    <= 1'b0;
        u_in.valid <= 1'b0;
        u_in.item  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames: short, truncated at each field, odd header lengths, extremes.
        send_frame(1, 0, 16'h0, 4'd0, 8'd0, 16'h0000, FILL_RANDOM);
        send_frame(13, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, ftx_pkg::PROTO_TCP, 16'hFFFF,
                   FILL_RANDOM);
        send_frame(14, 1, ETYPE_IPV6, 4'd5, ftx_pkg::PROTO_TCP, 16'd14, FILL_RANDOM);
        send_frame(20, 1, ETYPE_NEAR, 4'd5, ftx_pkg::PROTO_UDP, 16'd20, FILL_RANDOM);
        send_frame(14, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, ftx_pkg::PROTO_TCP, 16'd1514,
                   FILL_RANDOM);
        send_frame(23, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, ftx_pkg::PROTO_TCP, 16'd64,
                   FILL_RANDOM);
        send_frame(24, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, ftx_pkg::PROTO_TCP, 16'd64,
                   FILL_RANDOM);
        send_frame(33, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, ftx_pkg::PROTO_UDP, 16'd64,
                   FILL_RANDOM);
        send_frame(37, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, ftx_pkg::PROTO_TCP, 16'd37,
                   FILL_RANDOM);
        send_frame(38, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, ftx_pkg::PROTO_TCP, 16'd38,
                   FILL_RANDOM);
        send_frame(60, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd15, ftx_pkg::PROTO_UDP, 16'd60,
                   FILL_RANDOM);
        send_frame(78, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd15, ftx_pkg::PROTO_UDP, 16'd78,
                   FILL_RANDOM);
        send_frame(24, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, PROTO_ICMP, 16'd24, FILL_RANDOM);
        send_frame(38, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, 8'hFF, 16'd38, FILL_RANDOM);
        send_frame(38, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, 8'h26, 16'd38, FILL_RANDOM);
        for (int h = 0; h <= 4; h++)
            send_frame(34, 1, ftx_pkg::ETHERTYPE_IPV4, 4'(h),
                       (h % 2) ? ftx_pkg::PROTO_UDP : ftx_pkg::PROTO_TCP,
                       16'($urandom), FILL_RANDOM);
        send_frame(20, 0, 16'h0, 4'd0, 8'd0, 16'h0000, FILL_ZERO);
        send_frame(20, 0, 16'h0, 4'd0, 8'd0, 16'hFFFF, FILL_ONE);
        send_frame(38, 1, ftx_pkg::ETHERTYPE_IPV4, 4'd5, ftx_pkg::PROTO_UDP, 16'hFFFF,
                   FILL_ONE);

        // Random frames, mostly well-formed TCP/UDP over IPv4.
        while (bytes_sent < 900) begin
            r = $urandom_range(0, 99);
            ihl = ($urandom_range(0, 9) < 6) ? 5 : $urandom_range(0, 15);
            need = ftx_pkg::OFF_IP_START + 4 * ihl + ftx_pkg::PORT_LAST_REL + 1;
            if (need < ftx_pkg::OFF_DST_LAST + 1) need = ftx_pkg::OFF_DST_LAST + 1;
            if ($urandom_range(0, 99) < 15) len = $urandom_range(1, need - 1);
            else len = need + $urandom_range(0, 30);
            if (r < 70) begin
                proto = $urandom_range(0, 1) ? ftx_pkg::PROTO_TCP : ftx_pkg::PROTO_UDP;
                send_frame(len, 1, ftx_pkg::ETHERTYPE_IPV4, 4'(ihl), proto, 16'($urandom),
                           FILL_RANDOM);
            end else if (r < 80) begin
                send_frame(len, 1, ftx_pkg::ETHERTYPE_IPV4, 4'(ihl), 8'($urandom),
                           16'($urandom), FILL_RANDOM);
            end else if (r < 90) begin
                send_frame($urandom_range(1, 80), 1, 16'($urandom), 4'(ihl), 8'($urandom),
                           16'($urandom), FILL_RANDOM);
            end else begin
                send_frame($urandom_range(1, 80), 0, 16'h0, 4'd0, 8'd0, 16'($urandom),
                           FILL_RANDOM);
            end
        end

        u_in.valid <= 1'b0;
        @(posedge i_clk);
        while (records_pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/ftx_pkg.sv
design/ftx_if.sv
design/ftx_parser.sv
design/eth_ipv4_five_tuple_extractor.sv
design/ftx_checker.sv
dv/ftx_record_checker.sv
dv/testbench.sv
